[rtl/text_console_writer_assert.svh]
// Assertion macros shared by the console writer modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`define TCW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`define TCW_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tcw_pkg.sv]
package tcw_pkg;

  localparam int unsigned COLUMNS_DEFAULT = 80;
  localparam int unsigned ROWS_DEFAULT    = 25;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned IDX_W     = 11;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned CELL_W    = 16;
  localparam int unsigned ROW_OUT_W = 5;
  localparam int unsigned COL_OUT_W = 7;

  localparam logic [MODE_W-1:0] MODE_PUT       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BACKSPACE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ      = 2'd3;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE     = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CODE       = 8'h20;
  localparam logic [CELL_W-1:0]  BLANK_CELL       = 16'h0720;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd7;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ
  } cmd_op_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] character;
    logic [IDX_W-1:0]  cell_index;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0]    read_value;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_column;
    logic                 scrolled;
  } result_t;

  typedef struct packed {
    cmd_op_e           op;
    logic [CHAR_W-1:0] character;
    logic [IDX_W-1:0]  cell_index;
    logic              index_ok;
  } cmd_t;

endpackage

[rtl/tcw_ram.sv]
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tcw_front.sv]
`include "text_console_writer_assert.svh"

module tcw_front #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tcw_pkg::item_t in_data_i,
  output logic           cmd_valid_o,
  output tcw_pkg::cmd_t  cmd_o,
  input  logic           cmd_pop_i
);
  import tcw_pkg::*;

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned AW     = $clog2(CELLS);
  localparam int unsigned CMPW   = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  cmd_t              cmd_new;
  cmd_t              entries_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              accept;

  always_comb begin
    cmd_new.character  = in_data_i.character;
    cmd_new.cell_index = in_data_i.cell_index;
    cmd_new.index_ok   = CMPW'(in_data_i.cell_index) < CMPW'(CELLS);
    case (in_data_i.mode)
      MODE_PUT: begin
        cmd_new.op = (in_data_i.character == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
      end
      MODE_BACKSPACE: cmd_new.op = OP_BACKSPACE;
      MODE_CLEAR:     cmd_new.op = OP_CLEAR;
      MODE_READ:      cmd_new.op = OP_READ;
      default:        cmd_new.op = OP_READ;
    endcase
  end

  assign in_stall_o  = (count_q == QCNT_W'(QDEPTH));
  assign accept      = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = accept ? QPTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? QPTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (accept && !cmd_pop_i) begin
      count_d = QCNT_W'(count_q + 1'b1);
    end else if (!accept && cmd_pop_i) begin
      count_d = QCNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entries_q[wr_ptr_q] <= cmd_new;
    end
  end

  `TCW_ASSERT_ALWAYS(a_queue_bound, count_q <= QCNT_W'(QDEPTH), "Queue count exceeds its depth.")
  `TCW_ASSERT_IMPLIES(a_pop_nonempty, cmd_pop_i, count_q != '0, "Command popped from an empty queue.")

endmodule

[rtl/tcw_back.sv]
`include "text_console_writer_assert.svh"

module tcw_back #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [tcw_pkg::COLOR_W-1:0]     text_color_i,
  input  logic                            cmd_valid_i,
  input  tcw_pkg::cmd_t                   cmd_i,
  output logic                            cmd_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tcw_pkg::result_t                out_data_o
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CLW   = $clog2(COLUMNS);

  localparam logic [AW-1:0]  LAST_BASE = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0]  LAST_CELL = AW'(CELLS - 1);
  localparam logic [RW-1:0]  LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CLW-1:0] LAST_COL  = CLW'(COLUMNS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_COPY  = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CLW-1:0]    col_q, col_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic              out_valid_q;
  result_t           out_data_q;
  logic              out_free;
  logic              load_res;
  logic [CELL_W-1:0] res_read;
  logic              res_scr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [CELL_W-1:0] rdata;

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    cmd_pop_o = 1'b0;
    load_res  = 1'b0;
    res_read  = '0;
    res_scr   = 1'b0;
    we        = 1'b0;
    waddr     = cnt_q;
    wdata     = BLANK_CELL;
    raddr     = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_PUT, OP_NEWLINE: begin
              if (cmd_i.op == OP_PUT) begin
                we    = 1'b1;
                waddr = addr_q;
                wdata = {text_color_i, cmd_i.character};
              end
              if (cmd_i.op == OP_PUT && col_q != LAST_COL) begin
                col_d    = CLW'(col_q + 1'b1);
                addr_d   = AW'(addr_q + 1'b1);
                load_res = 1'b1;
              end else begin
                col_d = '0;
                if (row_q == LAST_ROW) begin
                  addr_d  = LAST_BASE;
                  cnt_d   = '0;
                  state_d = ST_COPY;
                end else begin
                  row_d    = RW'(row_q + 1'b1);
                  load_res = 1'b1;
                  if (cmd_i.op == OP_PUT) begin
                    addr_d = AW'(addr_q + 1'b1);
                  end else begin
                    addr_d = AW'(addr_q - AW'(col_q) + AW'(COLUMNS));
                  end
                end
              end
            end
            OP_BACKSPACE: begin
              load_res = 1'b1;
              if (col_q != '0 || row_q != '0) begin
                we     = 1'b1;
                waddr  = AW'(addr_q - 1'b1);
                wdata  = {text_color_i, SPACE_CODE};
                addr_d = AW'(addr_q - 1'b1);
                if (col_q == '0) begin
                  row_d = RW'(row_q - 1'b1);
                  col_d = LAST_COL;
                end else begin
                  col_d = CLW'(col_q - 1'b1);
                end
              end
            end
            OP_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              addr_d  = '0;
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end
            OP_READ: begin
              if (cmd_i.index_ok) begin
                raddr   = AW'(cmd_i.cell_index);
                state_d = ST_READ;
              end else begin
                load_res = 1'b1;
              end
            end
            default: load_res = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        load_res = 1'b1;
        res_read = rdata;
        state_d  = ST_IDLE;
      end
      ST_COPY: begin
        if (cnt_q != '0) begin
          we    = 1'b1;
          waddr = AW'(cnt_q - 1'b1);
          wdata = rdata;
        end
        if (cnt_q == LAST_BASE) begin
          state_d = ST_FILL;
        end else begin
          raddr = AW'(cnt_q + AW'(COLUMNS));
          cnt_d = AW'(cnt_q + 1'b1);
        end
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = {text_color_i, SPACE_CODE};
        if (cnt_q == LAST_CELL) begin
          load_res = 1'b1;
          res_scr  = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          cnt_d = AW'(cnt_q + 1'b1);
        end
      end
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = BLANK_CELL;
        if (cnt_q == LAST_CELL) begin
          load_res = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          cnt_d = AW'(cnt_q + 1'b1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      addr_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      out_data_q.read_value    <= res_read;
      out_data_q.cursor_row    <= ROW_OUT_W'(row_d);
      out_data_q.cursor_column <= COL_OUT_W'(col_d);
      out_data_q.scrolled      <= res_scr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `TCW_ASSERT_ALWAYS(a_addr_tracks_cursor,
      int'(addr_q) == int'(row_q) * int'(COLUMNS) + int'(col_q),
      "Cursor address does not match row and column.")
  `TCW_ASSERT_IMPLIES(a_scroll_cursor, load_res && res_scr,
      row_d == LAST_ROW && col_d == '0, "Scroll finished with the cursor off the bottom row start.")
  `TCW_ASSERT_NEXT(a_copy_exit, state_q == ST_COPY,
      state_q == ST_COPY || state_q == ST_FILL, "Row copy left without filling the bottom row.")
  `TCW_ASSERT_IMPLIES(a_no_result_overwrite, load_res,
      !out_valid_q || !out_stall_i, "Result written over one that is still held.")

endmodule

[rtl/text_console_writer.sv]
// Text console writer. Transactions on the input channel carry a mode, a character and a cell
// index, and each produces exactly one result with the read value, the cursor after the
// transaction and a scroll flag. Putting a character, a newline or a backspace is done in the
// idle state once the result register is free, unless it scrolls; reading a cell goes through
// a read state for the registered read of the screen memory. A scroll copies the store up one
// row, one cell per cycle, through the single read and single write port of the screen memory
// and then blanks the bottom row; a clear writes one cell per cycle. A two-entry command queue
// keeps accepting input until it is full while the back end works or a result waits.
// The screen is not cleared after reset: issue a clear before reading any cell. The color
// register resets to 7 and must be written only while the block is idle, which is not enforced.
module text_console_writer #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tcw_pkg::item_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tcw_pkg::result_t            out_data_o,
  input  logic                        cfg_we_i,
  input  logic [tcw_pkg::COLOR_W-1:0] cfg_data_i
);
  import tcw_pkg::*;

  logic [COLOR_W-1:0] color_q;
  logic               cmd_valid;
  cmd_t               cmd;
  logic               cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= TEXT_COLOR_RESET;
    end else if (cfg_we_i) begin
      color_q <= cfg_data_i;
    end
  end

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_color_i(color_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[test/text_console_writer_test.sv]
module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLUMNS = COLUMNS_DEFAULT;
  localparam int ROWS = ROWS_DEFAULT;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 106;
  localparam int HOLD_AFTER = 200;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } directed_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  item_t                in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  result_t              out_data_o;
  logic                 cfg_we_i;
  logic [COLOR_W-1:0]   cfg_data_i;

  logic [CELL_W-1:0]    screen_mem [CELLS];
  bit                   cell_known [CELLS];
  logic [ROW_OUT_W-1:0] cur_row;
  logic [COL_OUT_W-1:0] cur_col;
  logic [COLOR_W-1:0]   text_color;

  result_t              due_reports [$];
  directed_row_t        directed_rows [$];
  result_t              oldest_report;
  int                   mismatch_count;
  int                   reports_seen;
  bit                   calm;

  text_console_writer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #24000000;
    $display("text_console_writer_test: FAIL");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic bit advance_row();
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
        screen_mem[i] = screen_mem[i + COLUMNS];
        cell_known[i] = cell_known[i + COLUMNS];
      end
      for (int x = CELLS - COLUMNS; x < CELLS; x++) begin
        screen_mem[x] = {text_color, SPACE_CODE};
        cell_known[x] = 1'b1;
      end
      cur_row = ROW_OUT_W'(ROWS - 1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void blank_at_cursor();
    int idx;
    idx = int'(cur_row) * COLUMNS + int'(cur_col);
    screen_mem[idx] = {text_color, SPACE_CODE};
    cell_known[idx] = 1'b1;
  endfunction

  function automatic result_t apply_console_item(item_t it);
    result_t r;
    int idx;
    r = '0;
    case (it.mode)
      MODE_PUT: begin
        if (it.character == NEWLINE_CODE) begin
          cur_col = '0;
          r.scrolled = advance_row();
        end else begin
          idx = int'(cur_row) * COLUMNS + int'(cur_col);
          screen_mem[idx] = {text_color, it.character};
          cell_known[idx] = 1'b1;
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = '0;
            r.scrolled = advance_row();
          end
        end
      end
      MODE_BACKSPACE: begin
        if (cur_col == 0) begin
          if (cur_row != 0) begin
            cur_row--;
            cur_col = COL_OUT_W'(COLUMNS - 1);
            blank_at_cursor();
          end
        end else begin
          cur_col--;
          blank_at_cursor();
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          screen_mem[i] = BLANK_CELL;
          cell_known[i] = 1'b1;
        end
        cur_row = '0;
        cur_col = '0;
      end
      default: begin
        if (it.cell_index < CELLS) r.read_value = screen_mem[it.cell_index];
      end
    endcase
    r.cursor_row = cur_row;
    r.cursor_column = cur_col;
    return r;
  endfunction

  function automatic directed_row_t dir_row(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                                            logic [IDX_W-1:0] idx, bit typed,
                                            logic [CELL_W-1:0] rv, int row, int col, bit scr);
    directed_row_t d;
    d.stim.mode = mode;
    d.stim.character = ch;
    d.stim.cell_index = idx;
    d.typed = typed;
    d.want.read_value = rv;
    d.want.cursor_row = ROW_OUT_W'(row);
    d.want.cursor_column = COL_OUT_W'(col);
    d.want.scrolled = scr;
    return d;
  endfunction

  function automatic logic [IDX_W-1:0] choose_read_index();
    int idx;
    if ($urandom_range(0, 99) < 15) return IDX_W'($urandom_range(CELLS, 2047));
    for (int t = 0; t < 64; t++) begin
      idx = $urandom_range(0, CELLS - 1);
      if (cell_known[idx]) return IDX_W'(idx);
    end
    return IDX_W'($urandom_range(CELLS, 2047));
  endfunction

  function automatic item_t random_item(int put_pct, int nl_pct);
    item_t it;
    int r;
    it.character = CHAR_W'($urandom_range(0, 255));
    it.cell_index = IDX_W'($urandom_range(0, 2047));
    r = $urandom_range(0, 99);
    if (r < put_pct) begin
      it.mode = MODE_PUT;
      if ($urandom_range(0, 99) < nl_pct) it.character = NEWLINE_CODE;
      else if ($urandom_range(0, 99) < 80) it.character = CHAR_W'($urandom_range(8'h20, 8'h7e));
    end else if (r < put_pct + 2) begin
      it.mode = MODE_CLEAR;
    end else if (r < put_pct + 12) begin
      it.mode = MODE_BACKSPACE;
    end else begin
      it.mode = MODE_READ;
      it.cell_index = choose_read_index();
    end
    return it;
  endfunction

  task automatic send_item(item_t it, bit typed, result_t want);
    int gap;
    result_t predicted;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_console_item(it);
    due_reports.push_back(typed ? want : predicted);
  endtask

  task automatic set_text_color(logic [COLOR_W-1:0] value);
    in_valid_i <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    text_color = value;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reports_seen++;
      if (due_reports.size() == 0) begin
        report_mismatch("unexpected transaction", int'(out_data_o), 0);
      end else begin
        oldest_report = due_reports.pop_front();
        if (out_data_o.read_value !== oldest_report.read_value)
          report_mismatch("read_value", int'(out_data_o.read_value),
                          int'(oldest_report.read_value));
        if (out_data_o.cursor_row !== oldest_report.cursor_row)
          report_mismatch("cursor_row", int'(out_data_o.cursor_row),
                          int'(oldest_report.cursor_row));
        if (out_data_o.cursor_column !== oldest_report.cursor_column)
          report_mismatch("cursor_column", int'(out_data_o.cursor_column),
                          int'(oldest_report.cursor_column));
        if (out_data_o.scrolled !== oldest_report.scrolled)
          report_mismatch("scrolled", int'(out_data_o.scrolled),
                          int'(oldest_report.scrolled));
      end
    end
  end

  initial begin
    int hold_left;
    int n;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && reports_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        n = calm ? 0 : idle_len();
        out_stall_i <= (n > 0);
        hold_left = (n > 0) ? n - 1 : 0;
      end
    end
  end

  initial begin
    logic [COLOR_W-1:0] phase_colors [PHASES];
    int put_pct [PHASES];
    int nl_pct [PHASES];
    result_t unused;

    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    calm = 1'b0;
    mismatch_count = 0;
    reports_seen = 0;
    unused = '0;
    cur_row = '0;
    cur_col = '0;
    text_color = TEXT_COLOR_RESET;
    for (int i = 0; i < CELLS; i++) begin
      screen_mem[i] = '0;
      cell_known[i] = 1'b0;
    end

    phase_colors = '{8'h00, 8'hff, 8'h1e, 8'h00, 8'h00};
    phase_colors[3] = COLOR_W'($urandom_range(0, 255));
    phase_colors[4] = COLOR_W'($urandom_range(0, 255));
    put_pct = '{60, 60, 60, 88, 60};
    nl_pct = '{10, 10, 35, 1, 10};

    directed_rows.push_back(dir_row(MODE_PUT, 8'h41, 11'd0, 1, 16'h0000, 0, 1, 0));
    directed_rows.push_back(dir_row(MODE_READ, 8'h00, 11'd0, 1, 16'h0741, 0, 1, 0));
    directed_rows.push_back(dir_row(MODE_READ, 8'hff, 11'd2047, 1, 16'h0000, 0, 1, 0));
    directed_rows.push_back(dir_row(MODE_CLEAR, 8'h00, 11'd0, 1, 16'h0000, 0, 0, 0));
    directed_rows.push_back(dir_row(MODE_BACKSPACE, 8'h00, 11'd0, 1, 16'h0000, 0, 0, 0));
    directed_rows.push_back(dir_row(MODE_READ, 8'h00, 11'd0, 1, BLANK_CELL, 0, 0, 0));
    directed_rows.push_back(dir_row(MODE_READ, 8'h00, 11'd1999, 1, BLANK_CELL, 0, 0, 0));
    directed_rows.push_back(dir_row(MODE_PUT, 8'h00, 11'd2047, 1, 16'h0000, 0, 1, 0));
    directed_rows.push_back(dir_row(MODE_PUT, 8'hff, 11'd0, 1, 16'h0000, 0, 2, 0));
    directed_rows.push_back(dir_row(MODE_BACKSPACE, 8'hff, 11'd2047, 1, 16'h0000, 0, 1, 0));
    directed_rows.push_back(dir_row(MODE_READ, 8'h00, 11'd1, 1, BLANK_CELL, 0, 1, 0));
    directed_rows.push_back(dir_row(MODE_PUT, NEWLINE_CODE, 11'd0, 1, 16'h0000, 1, 0, 0));
    directed_rows.push_back(dir_row(MODE_BACKSPACE, 8'h00, 11'd0, 1, 16'h0000, 0, 79, 0));
    directed_rows.push_back(dir_row(MODE_READ, 8'h00, 11'd79, 1, BLANK_CELL, 0, 79, 0));
    directed_rows.push_back(dir_row(MODE_PUT, 8'h5a, 11'd0, 1, 16'h0000, 1, 0, 0));
    directed_rows.push_back(dir_row(MODE_READ, 8'h00, 11'd79, 1, 16'h075a, 1, 0, 0));
    directed_rows.push_back(dir_row(MODE_READ, 8'h00, 11'd2000, 1, 16'h0000, 1, 0, 0));
    directed_rows.push_back(dir_row(MODE_PUT, NEWLINE_CODE, 11'd0, 1, 16'h0000, 2, 0, 0));
    directed_rows.push_back(dir_row(MODE_READ, 8'h00, 11'd0, 1, 16'h0700, 2, 0, 0));
    directed_rows.push_back(dir_row(MODE_READ, 8'h00, 11'd1024, 0, 16'h0000, 0, 0, 0));
    directed_rows.push_back(dir_row(MODE_PUT, 8'h7f, 11'd0, 0, 16'h0000, 0, 0, 0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      set_text_color(phase_colors[p]);
      calm = (p == 1);
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_item(random_item(put_pct[p], nl_pct[p]), 1'b0, unused);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("text_console_writer_test: PASS");
    end else begin
      $display("text_console_writer_test: FAIL");
    end
    $finish;
  end

endmodule
